// ===== rtl/core/sbf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, action codes and command types for the segmented byte FIFO.
package sbf_pkg;

  localparam int SEGMENT_BYTES = 256;
  localparam int SEGMENTS      = 8;
  localparam int POOL_BYTES    = SEGMENT_BYTES * SEGMENTS;

  localparam int SEG_W    = $clog2(SEGMENTS);
  localparam int CNT_W    = $clog2(SEGMENTS + 1);
  localparam int OFF_W    = $clog2(SEGMENT_BYTES + 1);
  localparam int ADDR_W   = $clog2(POOL_BYTES);
  localparam int STORED_W = $clog2(POOL_BYTES + 1);

  localparam int ACTION_W     = 2;
  localparam int DATA_W       = 8;
  localparam int MOVED_W      = 16;
  localparam int STORED_OUT_W = 12;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  typedef struct packed {
    logic                    accepted;
    logic [MOVED_W-1:0]      moved;
    logic [STORED_OUT_W-1:0] stored;
    logic                    empty;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    res_t              res;
  } cmd_t;

endpackage

// ===== rtl/core/sbf_in_if.sv =====
`timescale 1ns / 1ps
// Input channel interface: action, byte and end-of-request flag.
interface sbf_in_if;
  logic                          valid;
  logic                          ready;
  logic [sbf_pkg::ACTION_W-1:0]  action;
  logic [sbf_pkg::DATA_W-1:0]    data_in;
  logic                          last_of_request;

  modport source (output valid, output action, output data_in, output last_of_request,
                  input ready);
  modport sink   (input valid, input action, input data_in, input last_of_request,
                  output ready);
endinterface

// ===== rtl/core/sbf_out_if.sv =====
`timescale 1ns / 1ps
// Result channel interface: status, byte read and counters per transaction.
interface sbf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             accepted;
  logic [sbf_pkg::DATA_W-1:0]       data_out;
  logic [sbf_pkg::MOVED_W-1:0]      request_moved;
  logic [sbf_pkg::STORED_OUT_W-1:0] stored_bytes;
  logic                             in_use_empty;

  modport source (output valid, output accepted, output data_out, output request_moved,
                  output stored_bytes, output in_use_empty, input ready);
  modport sink   (input valid, input accepted, input data_out, input request_moved,
                  input stored_bytes, input in_use_empty, output ready);
endinterface

// ===== rtl/core/segmented_byte_fifo.sv =====
`timescale 1ns / 1ps
// Segmented byte FIFO top level: front end, command queue and memory back end.
//
// in_chan carries one action per transaction: push a byte, pop a byte or
// flush every segment back to the free list. out_chan returns exactly one
// result per input transaction, in order: accepted flag, byte read, bytes
// moved in the current request, unread byte count and list-empty flag.
// Throughput is one transaction per cycle while out_chan.ready is high. The front
// end updates the segment lists and offsets as each transaction is accepted and
// the back end makes one access to the single segment RAM per transaction, so
// one RAM port pair sets the rate. An accepted input is registered into the
// command queue, then into the RAM stage, then into the output register.
// Reset puts all segments on the free list in index order and empties the
// in-use list; the segment RAM is not cleared and no clearing pass runs,
// so in_chan.ready is high from the first cycle after reset.
// When out_chan.ready is low the output register holds its result, the RAM
// stage and the two-entry command queue fill, and in_chan.ready drops once
// the queue is full.
module segmented_byte_fifo (
  input  logic      clk,
  input  logic      rst_n,
  sbf_in_if.sink    in_chan,
  sbf_out_if.source out_chan
);
  import sbf_pkg::*;

  logic fq_valid, fq_ready;
  cmd_t fq_data;
  logic qb_valid, qb_ready;
  cmd_t qb_data;

  sbf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .q_valid(fq_valid),
    .q_ready(fq_ready),
    .q_data (fq_data)
  );

  sbf_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data (fq_data),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data)
  );

  sbf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .out_chan(out_chan)
  );

endmodule

// ===== rtl/core/sbf_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
module sbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sbf_front.sv =====
`timescale 1ns / 1ps
// Front end: segment lists, offsets and counters; turns each transaction into a command.
module sbf_front (
  input  logic          clk,
  input  logic          rst_n,
  sbf_in_if.sink        in_chan,
  output logic          q_valid,
  input  logic          q_ready,
  output sbf_pkg::cmd_t q_data
);
  import sbf_pkg::*;

  logic [SEG_W-1:0]    free_ring_r [SEGMENTS];
  logic [SEG_W-1:0]    free_ring_nxt [SEGMENTS];
  logic [SEG_W-1:0]    use_ring_r [SEGMENTS];
  logic [SEG_W-1:0]    use_ring_nxt [SEGMENTS];
  logic [SEG_W-1:0]    free_head_r, free_head_nxt;
  logic [SEG_W-1:0]    use_head_r, use_head_nxt;
  logic [CNT_W-1:0]    use_count_r, use_count_nxt;
  logic [SEG_W-1:0]    head_seg_r, head_seg_nxt;
  logic [SEG_W-1:0]    tail_seg_r, tail_seg_nxt;
  logic [OFF_W-1:0]    tail_fill_r, tail_fill_nxt;
  logic [OFF_W-1:0]    read_off_r, read_off_nxt;
  logic [MOVED_W-1:0]  moved_r, moved_nxt;
  logic [STORED_W-1:0] stored_r, stored_nxt;

  logic               accept;
  logic [CNT_W-1:0]   free_count;
  logic               has_room;
  logic               can_take;
  logic [SEG_W-1:0]   take_seg;
  logic [OFF_W-1:0]   head_fill;
  logic [OFF_W-1:0]   pop_off;
  logic               head_done;
  logic [SEG_W-1:0]   next_head_seg;
  logic [SEG_W-1:0]   free_wr_idx;
  logic [SEG_W-1:0]   use_wr_idx;
  logic               acc;
  logic               is_flush;
  logic [MOVED_W-1:0] moved_base;
  logic [MOVED_W-1:0] moved_res;

  function automatic logic [SEG_W-1:0] ring_inc(input logic [SEG_W-1:0] p);
    return (p == SEG_W'(SEGMENTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SEG_W-1:0] ring_add(input logic [SEG_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(SEGMENTS)) begin
      s = s - (CNT_W+1)'(SEGMENTS);
    end
    return s[SEG_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] seg_addr(input logic [SEG_W-1:0] seg,
                                                 input logic [OFF_W-1:0] off);
    return ADDR_W'(seg) * ADDR_W'(SEGMENT_BYTES) + ADDR_W'(off);
  endfunction

  assign in_chan.ready = q_ready;
  assign accept        = in_chan.valid && q_ready;
  assign q_valid       = accept;

  assign free_count    = CNT_W'(SEGMENTS) - use_count_r;
  assign has_room      = (use_count_r != '0) && (tail_fill_r < OFF_W'(SEGMENT_BYTES));
  assign can_take      = (use_count_r != CNT_W'(SEGMENTS));
  assign take_seg      = free_ring_r[free_head_r];
  // only the tail segment can be partly filled; every older one is full
  assign head_fill     = (use_count_r == CNT_W'(1)) ? tail_fill_r : OFF_W'(SEGMENT_BYTES);
  assign pop_off       = read_off_r + 1'b1;
  assign head_done     = (pop_off >= head_fill);
  assign next_head_seg = use_ring_r[ring_add(use_head_r, CNT_W'(1))];
  assign free_wr_idx   = ring_add(free_head_r, free_count);
  assign use_wr_idx    = ring_add(use_head_r, use_count_r);

  always_comb begin
    free_ring_nxt = free_ring_r;
    use_ring_nxt  = use_ring_r;
    free_head_nxt = free_head_r;
    use_head_nxt  = use_head_r;
    use_count_nxt = use_count_r;
    head_seg_nxt  = head_seg_r;
    tail_seg_nxt  = tail_seg_r;
    tail_fill_nxt = tail_fill_r;
    read_off_nxt  = read_off_r;
    moved_nxt     = moved_r;
    stored_nxt    = stored_r;
    acc           = 1'b0;
    is_flush      = 1'b0;
    moved_base    = moved_r;
    moved_res     = moved_r;
    q_data        = '0;
    q_data.wdata  = in_chan.data_in;

    if (accept) begin
      unique case (in_chan.action)
        ACT_PUSH: begin
          if (has_room) begin
            acc           = 1'b1;
            q_data.wr_en  = 1'b1;
            q_data.addr   = seg_addr(tail_seg_r, tail_fill_r);
            tail_fill_nxt = tail_fill_r + 1'b1;
            stored_nxt    = stored_r + 1'b1;
          end else if (can_take) begin
            acc                      = 1'b1;
            q_data.wr_en             = 1'b1;
            q_data.addr              = seg_addr(take_seg, '0);
            free_head_nxt            = ring_inc(free_head_r);
            use_ring_nxt[use_wr_idx] = take_seg;
            use_count_nxt            = use_count_r + 1'b1;
            tail_seg_nxt             = take_seg;
            if (use_count_r == '0) begin
              head_seg_nxt = take_seg;
            end
            tail_fill_nxt = OFF_W'(1);
            stored_nxt    = stored_r + 1'b1;
          end
        end
        ACT_POP: begin
          if (use_count_r != '0) begin
            acc          = 1'b1;
            q_data.rd_en = 1'b1;
            q_data.addr  = seg_addr(head_seg_r, read_off_r);
            stored_nxt   = stored_r - 1'b1;
            if (head_done) begin
              // segment drained: back to the free tail, even if it is the tail
              read_off_nxt               = '0;
              use_head_nxt               = ring_inc(use_head_r);
              use_count_nxt              = use_count_r - 1'b1;
              free_ring_nxt[free_wr_idx] = head_seg_r;
              head_seg_nxt               = next_head_seg;
              if (use_count_r == CNT_W'(1)) begin
                tail_fill_nxt = '0;
              end
            end else begin
              read_off_nxt = pop_off;
            end
          end
        end
        ACT_FLUSH: begin
          is_flush = 1'b1;
          for (int i = 0; i < SEGMENTS; i++) begin
            free_ring_nxt[i] = SEG_W'(i);
          end
          free_head_nxt = '0;
          use_head_nxt  = '0;
          use_count_nxt = '0;
          tail_fill_nxt = '0;
          read_off_nxt  = '0;
          stored_nxt    = '0;
        end
        default: begin
        end
      endcase

      moved_base = is_flush ? '0 : moved_r;
      moved_res  = (acc && (moved_base != '1)) ? moved_base + 1'b1 : moved_base;
      moved_nxt  = in_chan.last_of_request ? '0 : moved_res;

      q_data.res.accepted = acc;
      q_data.res.moved    = moved_res;
      q_data.res.stored   = STORED_OUT_W'(stored_nxt);
      q_data.res.empty    = (use_count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        free_ring_r[i] <= SEG_W'(i);
      end
      free_head_r <= '0;
      use_head_r  <= '0;
      use_count_r <= '0;
      tail_fill_r <= '0;
      read_off_r  <= '0;
      moved_r     <= '0;
      stored_r    <= '0;
    end else begin
      free_ring_r <= free_ring_nxt;
      free_head_r <= free_head_nxt;
      use_head_r  <= use_head_nxt;
      use_count_r <= use_count_nxt;
      tail_fill_r <= tail_fill_nxt;
      read_off_r  <= read_off_nxt;
      moved_r     <= moved_nxt;
      stored_r    <= stored_nxt;
    end
  end

  // list entries and segment pointers are only read once written
  always_ff @(posedge clk) begin
    use_ring_r <= use_ring_nxt;
    head_seg_r <= head_seg_nxt;
    tail_seg_r <= tail_seg_nxt;
  end

endmodule

// ===== rtl/core/sbf_cmd_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the memory back end.
module sbf_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sbf_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output sbf_pkg::cmd_t pop_data
);
  import sbf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/sbf_back.sv =====
`timescale 1ns / 1ps
// Back end: segment memory access and the result output register.
module sbf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  sbf_pkg::cmd_t q_data,
  sbf_out_if.source     out_chan
);
  import sbf_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  cmd_t              s1_cmd_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] ram_rdata;
  logic              s1_move;
  logic              take;

  assign s1_move = s1_valid_r && (!out_valid_r || out_chan.ready);
  // a new access only when the stage holding the read data is empty or moves on,
  // so the RAM read register holds while stalled
  assign take    = q_valid && (!s1_valid_r || s1_move);
  assign q_ready = !s1_valid_r || s1_move;

  sbf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(POOL_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (take && q_data.wr_en),
    .waddr(q_data.addr),
    .wdata(q_data.wdata),
    .re   (take && q_data.rd_en),
    .raddr(q_data.addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    s1_valid_nxt  = take || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd_r <= q_data;
    end
    if (s1_move) begin
      out_res_r  <= s1_cmd_r.res;
      out_data_r <= s1_cmd_r.rd_en ? ram_rdata : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.accepted      = out_res_r.accepted;
  assign out_chan.data_out      = out_data_r;
  assign out_chan.request_moved = out_res_r.moved;
  assign out_chan.stored_bytes  = out_res_r.stored;
  assign out_chan.in_use_empty  = out_res_r.empty;

endmodule

// ===== rtl/core/sbf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the segmented byte FIFO result channel, bound to the top level.
module sbf_port_checks (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_accepted,
  input logic [sbf_pkg::DATA_W-1:0]       out_data_out,
  input logic [sbf_pkg::MOVED_W-1:0]      out_request_moved,
  input logic [sbf_pkg::STORED_OUT_W-1:0] out_stored_bytes,
  input logic                             out_in_use_empty
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_data_out == '0)
    else $error("non-zero byte on a refused transaction");

  a_moved_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_request_moved != '0)
    else $error("accepted transaction not counted in request");

  a_empty_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_use_empty |-> out_stored_bytes == '0)
    else $error("bytes reported with no segment in use");

endmodule

bind segmented_byte_fifo sbf_port_checks u_sbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_accepted     (out_chan.accepted),
  .out_data_out     (out_chan.data_out),
  .out_request_moved(out_chan.request_moved),
  .out_stored_bytes (out_chan.stored_bytes),
  .out_in_use_empty (out_chan.in_use_empty)
);

// ===== verif/sbf_checker.sv =====
`timescale 1ns / 1ps
// Checker for the segmented byte FIFO: watches both channels, predicts each result, compares.
module sbf_checker (
  input  logic clk,
  input  logic rst_n,
  sbf_in_if    in_mon,
  sbf_out_if   out_mon,
  output int   mismatch_count,
  output int   results_pending
);
  import sbf_pkg::*;

  typedef struct {
    logic                    accepted;
    logic [DATA_W-1:0]       data;
    logic [MOVED_W-1:0]      moved;
    logic [STORED_OUT_W-1:0] stored;
    logic                    empty;
  } fifo_result_t;

  logic [DATA_W-1:0]  seg_mem   [POOL_BYTES];
  logic [OFF_W-1:0]   seg_fill  [SEGMENTS];
  logic [SEG_W-1:0]   free_list [SEGMENTS];
  logic [SEG_W-1:0]   use_list  [SEGMENTS];
  logic [SEG_W-1:0]   free_hd;
  logic [SEG_W-1:0]   use_hd;
  logic [CNT_W-1:0]   free_cnt;
  logic [CNT_W-1:0]   use_cnt;
  logic [OFF_W-1:0]   rd_off;
  logic [MOVED_W-1:0] moved_run;

  fifo_result_t expected_results[$];

  function automatic void release_all_segments();
    for (int i = 0; i < SEGMENTS; i++) begin
      free_list[i] = SEG_W'(i);
      seg_fill[i]  = '0;
    end
    free_hd  = '0;
    free_cnt = CNT_W'(SEGMENTS);
    use_hd   = '0;
    use_cnt  = '0;
    rd_off   = '0;
  endfunction

  // One transaction through the segment lists; queues the result it should produce.
  function automatic void predict_fifo_step(input logic [ACTION_W-1:0] act,
                                            input logic [DATA_W-1:0] din,
                                            input logic lst);
    fifo_result_t      r;
    logic [SEG_W-1:0]  seg;
    logic              room;
    logic              took;
    logic [DATA_W-1:0] rd;
    int                total;
    seg   = '0;
    room  = 1'b0;
    took  = 1'b0;
    rd    = '0;
    total = 0;
    case (act)
      ACT_PUSH: begin
        if (use_cnt != 0) begin
          seg  = use_list[SEG_W'(int'(use_hd) + int'(use_cnt) - 1)];
          room = seg_fill[seg] < OFF_W'(SEGMENT_BYTES);
        end
        if (!room && free_cnt != 0) begin
          seg      = free_list[free_hd];
          free_hd  = free_hd + 1'b1;
          free_cnt = free_cnt - 1'b1;
          use_list[SEG_W'(int'(use_hd) + int'(use_cnt))] = seg;
          use_cnt  = use_cnt + 1'b1;
          room     = 1'b1;
        end
        if (room) begin
          seg_mem[int'(seg) * SEGMENT_BYTES + int'(seg_fill[seg])] = din;
          seg_fill[seg] = seg_fill[seg] + 1'b1;
          took = 1'b1;
        end
      end
      ACT_POP: begin
        if (use_cnt != 0) begin
          seg = use_list[use_hd];
          if (rd_off < seg_fill[seg]) begin
            rd     = seg_mem[int'(seg) * SEGMENT_BYTES + int'(rd_off)];
            rd_off = rd_off + 1'b1;
            took   = 1'b1;
          end
          // head segment fully read: back to the free tail, even if it is also the tail
          if (rd_off >= seg_fill[seg]) begin
            seg_fill[seg] = '0;
            rd_off   = '0;
            use_hd   = use_hd + 1'b1;
            use_cnt  = use_cnt - 1'b1;
            free_list[SEG_W'(int'(free_hd) + int'(free_cnt))] = seg;
            free_cnt = free_cnt + 1'b1;
          end
        end
      end
      ACT_FLUSH: begin
        release_all_segments();
        moved_run = '0;
      end
      default: ;
    endcase

    if (took && moved_run != {MOVED_W{1'b1}})
      moved_run = moved_run + 1'b1;

    for (int i = 0; i < SEGMENTS; i++)
      total += int'(seg_fill[i]);
    total -= int'(rd_off);

    r.accepted = took;
    r.data     = took ? rd : '0;
    r.moved    = moved_run;
    r.stored   = STORED_OUT_W'(total);
    r.empty    = (use_cnt == 0);
    expected_results.push_back(r);

    if (lst)
      moved_run = '0;
  endfunction

  function automatic void check_field(input string field, input logic [MOVED_W-1:0] want,
                                      input logic [MOVED_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst_n) begin
      release_all_segments();
      moved_run = '0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] result transaction with nothing expected", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", MOVED_W'(want.accepted), MOVED_W'(out_mon.accepted));
          check_field("data_out", MOVED_W'(want.data), MOVED_W'(out_mon.data_out));
          check_field("request_moved", want.moved, out_mon.request_moved);
          check_field("stored_bytes", MOVED_W'(want.stored), MOVED_W'(out_mon.stored_bytes));
          check_field("in_use_empty", MOVED_W'(want.empty), MOVED_W'(out_mon.in_use_empty));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_fifo_step(in_mon.action, in_mon.data_in, in_mon.last_of_request);
    end
    results_pending = expected_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the segmented byte FIFO: clock, reset, stimulus, receiver stalls, verdict.
module tb_top;
  import sbf_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int TOTAL_ITEMS = 850;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 100_000;

  typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;
  typedef enum int {RUN_PUSH, RUN_POP, RUN_MIXED} run_kind_t;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   results_pending;
  int   items_sent;
  int   burst_left;

  sbf_in_if  in_chan ();
  sbf_out_if out_chan ();

  segmented_byte_fifo dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sbf_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] din,
                           input logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_chan.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid           <= 1'b1;
    in_chan.action          <= act;
    in_chan.data_in         <= din;
    in_chan.last_of_request <= lst;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_run(input int len, input run_kind_t kind);
    logic [ACTION_W-1:0] act;
    for (int i = 0; i < len; i++) begin
      case (kind)
        RUN_PUSH: act = ACT_PUSH;
        RUN_POP:  act = ACT_POP;
        default:  act = ($urandom_range(0, 1) != 0) ? ACT_PUSH : ACT_POP;
      endcase
      send_item(act, DATA_W'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_for_drain();
    in_chan.valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  initial begin
    int        pick;
    int        run_len;
    run_kind_t kind;
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.action          = ACT_PUSH;
    in_chan.data_in         = '0;
    in_chan.last_of_request = 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, unused code, byte extremes, tail segment freed on read,
    // flush mid-request, mixed request, end of request on refused and unused items
    send_item(ACT_POP, 8'h00, 1'b1);
    send_item(ACT_UNUSED, 8'hFF, 1'b0);
    send_item(ACT_PUSH, 8'h00, 1'b0);
    send_item(ACT_PUSH, 8'hFF, 1'b0);
    send_item(ACT_PUSH, 8'hA5, 1'b1);
    send_item(ACT_POP, 8'hFF, 1'b0);
    send_item(ACT_POP, 8'h00, 1'b0);
    send_item(ACT_POP, 8'h00, 1'b1);
    send_item(ACT_POP, 8'h00, 1'b1);
    send_item(ACT_PUSH, 8'h5A, 1'b0);
    send_item(ACT_PUSH, 8'h3C, 1'b0);
    send_item(ACT_FLUSH, 8'hFF, 1'b0);
    send_item(ACT_POP, 8'h00, 1'b1);
    send_item(ACT_PUSH, 8'h81, 1'b0);
    send_item(ACT_POP, 8'h00, 1'b0);
    send_item(ACT_UNUSED, 8'h00, 1'b1);
    send_item(ACT_PUSH, 8'h7E, 1'b1);
    send_item(ACT_UNUSED, 8'hFF, 1'b0);
    send_item(ACT_FLUSH, 8'h00, 1'b1);
    send_item(ACT_POP, 8'hFF, 1'b1);
    wait_for_drain();

    // random requests, mostly well formed, some long enough to cross segments
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(ACT_FLUSH, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 7) begin
        send_item(ACT_UNUSED, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 12) begin
        send_item(ACTION_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        run_len = (pick < 17) ? $urandom_range(200, 400) : $urandom_range(1, 40);
        if (run_len > TOTAL_ITEMS - items_sent)
          run_len = TOTAL_ITEMS - items_sent;
        if (pick < 30)
          kind = RUN_MIXED;
        else if (pick < 66)
          kind = RUN_PUSH;
        else
          kind = RUN_POP;
        send_run(run_len, kind);
      end
    end

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // receiver: one long hold-off that backs up the sender, otherwise shifting stall modes
  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    bit       held;
    out_chan.ready = 1'b0;
    rx_mode = RX_OPEN;
    rx_left = 0;
    held    = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
          RX_OPEN:  out_chan.ready <= 1'b1;
          RX_COIN:  out_chan.ready <= ($urandom_range(0, 1) != 0);
          RX_THIRD: out_chan.ready <= (rx_left % 3 == 0);
          default:  out_chan.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
